>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, quiet during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked during reset as well
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> src/frr_pkg.sv
// ----------------------------------------------------------------------------
// Frame reorder release package
// Widths, codes and types shared by the queue cells and the top level.
// ----------------------------------------------------------------------------
package frr_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TAG_BITS    = 16;
    localparam int MAX_RESULTS = 16;
    localparam int TS_W        = 63;
    localparam int WIN_W       = 40;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PROD_W      = $clog2(MAX_RESULTS + 1);
    localparam int ADDR_W      = 4;
    localparam int APB_W       = 64;
    localparam int IN_DATA_W   = 184;
    localparam int OUT_DATA_W  = 80;
    localparam int DROPPED_BIT = 1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(60000000);

    localparam logic [1:0] OP_FRAME       = 2'd0;
    localparam logic [1:0] OP_SEGMENT     = 2'd1;
    localparam logic [1:0] OP_FLUSH_START = 2'd2;
    localparam logic [1:0] OP_FLUSH_STOP  = 2'd3;

    localparam logic REG_WINDOW = 1'b0;

    typedef struct packed {
        logic [TS_W-1:0]     ts;
        logic [TAG_BITS-1:0] tag;
        logic                gap;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_cmd;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [TS_W-1:0]     ts;
        logic                disc;
    } t_result;

endpackage

>>> src/frr_cell.sv
// ----------------------------------------------------------------------------
// Frame reorder queue cell
// One slot of the sorted queue: shifts toward the head on release, and on
// insert keeps, takes the new entry or takes its left neighbour.
// ----------------------------------------------------------------------------
module frr_cell
    import frr_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_cmd i_cmd,
    input  logic      i_used,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_lt,
    input  t_entry    i_right,
    output t_entry    o_entry,
    output logic      o_lt
);

    t_entry r_entry;
    t_entry n_entry;

    assign o_lt    = i_used && (r_entry.ts < i_new.ts);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.pop) begin
            n_entry = i_right;
        end else if (i_cmd.insert && !o_lt) begin
            n_entry = i_left_lt ? i_new : i_left;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> src/frame_reorder_release.sv
// ----------------------------------------------------------------------------
// Frame reorder release
// Sorted frame queue built from a chain of cells, with head release control.
// ----------------------------------------------------------------------------
// Stream events are handled in the idle state. A frame report goes through
// accept, one forced head release when the queue is full, one insert, the head
// releases (at most 16), a step that ends the release loop and a step that
// closes the run. Output stalls can hold the forced release, the release loop
// and the closing step.
// Reset is synchronous: queue empty, window 60000000 ns; cells keep contents.
module frame_reorder_release
    import frr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // timestamp, inter_frame, decode_error, info_flags, image_missing,
    // format_mismatch, frame_tag, segment_begin, segment_in_time, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // operation
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_tag, out_timestamp, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // discontinuity
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FORCE   = 3'd1;
    localparam logic [2:0] ST_INSERT  = 3'd2;
    localparam logic [2:0] ST_RELEASE = 3'd3;
    localparam logic [2:0] ST_FINISH  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [WIN_W-1:0]  r_window, n_window;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TS_W-1:0]   r_last_ts, n_last_ts;
    logic              r_last_known, n_last_known;
    logic              r_seg_fresh, n_seg_fresh;
    logic              r_flushing, n_flushing;
    logic [TS_W-1:0]   r_seg_start, n_seg_start;
    logic              r_inter, n_inter;
    t_entry            r_new, n_new;
    logic [PROD_W-1:0] r_produced, n_produced;
    logic              r_pend_v, n_pend_v;
    t_result           r_pend, n_pend;
    logic              r_out_v, n_out_v;
    t_result           r_out, n_out;
    logic              r_out_last, n_out_last;

    logic [1:0]        w_op;
    logic [TS_W-1:0]   w_ts;
    logic [TS_W-1:0]   w_seg_begin;
    logic              w_gap;
    logic              w_accept;
    logic              w_cfg_wr;
    t_cell_cmd         w_cmd;
    t_entry            w_entry [QUEUE_DEPTH];
    logic              w_lt    [QUEUE_DEPTH];
    t_entry            w_head;
    logic              w_go;
    logic              w_want_pop;
    logic              w_do_pop;
    logic              w_out_free;
    logic              w_emit_room;
    logic [TS_W:0]     w_limit;

    assign w_op        = s_tuser;
    assign w_ts        = s_tdata[62:0];
    assign w_seg_begin = s_tdata[177:115];
    assign w_gap       = s_tdata[64] | s_tdata[65 + DROPPED_BIT] | s_tdata[97] | s_tdata[98];
    assign s_tready    = (r_state == ST_IDLE);
    assign w_accept    = s_tvalid && s_tready;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[3] == REG_WINDOW);
    assign prdata   = (paddr[3] == REG_WINDOW) ? {(APB_W - WIN_W)'(0), r_window} : '0;

    assign w_cmd.insert = (r_state == ST_INSERT);
    assign w_cmd.pop    = w_do_pop;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            t_entry w_left;
            logic   w_left_lt;
            t_entry w_right;
            if (gi == 0) begin : g_first
                assign w_left    = r_new;
                assign w_left_lt = 1'b1;
            end else begin : g_mid
                assign w_left    = w_entry[gi-1];
                assign w_left_lt = w_lt[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1) begin : g_last
                assign w_right = r_new;
            end else begin : g_inner
                assign w_right = w_entry[gi+1];
            end
            frr_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (w_cmd),
                .i_used    (CNT_W'(gi) < r_count),
                .i_new     (r_new),
                .i_left    (w_left),
                .i_left_lt (w_left_lt),
                .i_right   (w_right),
                .o_entry   (w_entry[gi]),
                .o_lt      (w_lt[gi])
            );
        end
    endgenerate

    assign w_head      = w_entry[0];
    assign w_limit     = {1'b0, r_last_ts} + {(TS_W + 1 - WIN_W)'(0), r_window};
    assign w_go        = !r_last_known || ({1'b0, w_head.ts} <= w_limit)
                         || (!r_inter && (w_head.ts < r_new.ts));
    assign w_want_pop  = (r_state == ST_FORCE)
                         || ((r_state == ST_RELEASE) && (r_count != '0)
                             && (r_produced < PROD_W'(MAX_RESULTS)) && w_go);
    assign w_out_free  = !r_out_v || m_tready;
    assign w_emit_room = !r_pend_v || w_out_free;
    assign w_do_pop    = w_want_pop && (w_head.gap || w_emit_room);

    always_comb begin
        n_state      = r_state;
        n_window     = r_window;
        n_count      = r_count;
        n_last_ts    = r_last_ts;
        n_last_known = r_last_known;
        n_seg_fresh  = r_seg_fresh;
        n_flushing   = r_flushing;
        n_seg_start  = r_seg_start;
        n_inter      = r_inter;
        n_new        = r_new;
        n_produced   = r_produced;
        n_pend_v     = r_pend_v;
        n_pend       = r_pend;
        n_out_v      = r_out_v && !m_tready;
        n_out        = r_out;
        n_out_last   = r_out_last;

        if (w_cfg_wr) begin
            n_window = pwdata[WIN_W-1:0];
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_op)
                        OP_SEGMENT: begin
                            n_seg_fresh  = 1'b1;
                            n_last_known = 1'b0;
                            if (s_tdata[178]) begin
                                n_seg_start = w_seg_begin;
                            end
                        end
                        OP_FLUSH_START: begin
                            n_flushing = 1'b1;
                        end
                        OP_FLUSH_STOP: begin
                            n_count     = '0;
                            n_seg_fresh = 1'b0;
                            n_seg_start = '0;
                            n_flushing  = 1'b0;
                        end
                        OP_FRAME: begin
                            if (!r_flushing && !(w_ts < r_seg_start)) begin
                                n_new.ts   = w_ts;
                                n_new.tag  = s_tdata[114:99];
                                n_new.gap  = w_gap;
                                n_inter    = s_tdata[63];
                                n_produced = '0;
                                n_state    = (r_count == CNT_W'(QUEUE_DEPTH)) ? ST_FORCE
                                                                               : ST_INSERT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_FORCE: begin
                if (w_do_pop) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_count = r_count + CNT_W'(1);
                n_state = ST_RELEASE;
            end
            ST_RELEASE: begin
                if (!w_want_pop) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_do_pop) begin
            n_count      = r_count - CNT_W'(1);
            n_last_ts    = w_head.ts;
            n_last_known = 1'b1;
            if (!w_head.gap) begin
                if (r_pend_v) begin
                    n_out_v    = 1'b1;
                    n_out      = r_pend;
                    n_out_last = 1'b0;
                end
                n_pend_v    = 1'b1;
                n_pend.tag  = w_head.tag;
                n_pend.ts   = w_head.ts;
                n_pend.disc = r_seg_fresh;
                n_seg_fresh = 1'b0;
                n_produced  = r_produced + PROD_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_window     <= WINDOW_RESET;
            r_count      <= '0;
            r_last_ts    <= '0;
            r_last_known <= 1'b0;
            r_seg_fresh  <= 1'b0;
            r_flushing   <= 1'b0;
            r_seg_start  <= '0;
            r_produced   <= '0;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_window     <= n_window;
            r_count      <= n_count;
            r_last_ts    <= n_last_ts;
            r_last_known <= n_last_known;
            r_seg_fresh  <= n_seg_fresh;
            r_flushing   <= n_flushing;
            r_seg_start  <= n_seg_start;
            r_produced   <= n_produced;
            r_pend_v     <= n_pend_v;
            r_out_v      <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inter    <= n_inter;
        r_new      <= n_new;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign m_tvalid = r_out_v;
    assign m_tdata  = {(OUT_DATA_W - TAG_BITS - TS_W)'(0), r_out.ts, r_out.tag};
    assign m_tuser  = r_out.disc;
    assign m_tlast  = r_out_last;

endmodule

>>> src/frr_checker.sv
// ----------------------------------------------------------------------------
// Frame reorder release checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frr_checker
    import frr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    `ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    `ASSERT_IMPL(a_busy_mid_run, i_clk, i_rst_n, m_tvalid && !m_tlast, !s_tready)
    `ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_tvalid)

endmodule

bind frame_reorder_release frr_checker u_frr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
